// File: rtl/core/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg: shared types, constants and helpers of the Playfair digram cipher
// Letter and key square types, register map and reset values.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned SideC   = 5;
  localparam int unsigned LetterW = 5;
  localparam int unsigned RowW    = SideC * LetterW;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [2:0]         coord_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
  } pair_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef enum logic [2:0] {
    RegMode   = 3'd0,
    RegFiller = 3'd1,
    RegRow0   = 3'd2,
    RegRow1   = 3'd3,
    RegRow2   = 3'd4,
    RegRow3   = 3'd5,
    RegRow4   = 3'd6
  } reg_idx_e;

  localparam letter_t LetterI    = 5'd8;
  localparam letter_t LetterJ    = 5'd9;
  localparam letter_t LastLetter = 5'd25;
  localparam coord_t  LastCoord  = 3'd4;

  localparam logic    ModeRst   = 1'b0;
  localparam letter_t FillerRst = 5'd23;
  localparam row_t    Row0Rst   = 25'd4294688;
  localparam row_t    Row1Rst   = 25'd10755269;
  localparam row_t    Row2Rst   = 25'd16201099;
  localparam row_t    Row3Rst   = 25'd21613104;
  localparam row_t    Row4Rst   = 25'd27025109;

  // j shares a cell with i
  function automatic letter_t fold_letter(letter_t v);
    return (v == LetterJ) ? LetterI : v;
  endfunction

  // one step along a row or column, wrapping at the edge
  function automatic coord_t wrap_step(coord_t x, logic dec);
    coord_t r;
    if (dec) begin
      r = (x == 3'd0) ? LastCoord : x - 3'd1;
    end else begin
      r = (x == LastCoord) ? 3'd0 : x + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pfd_map.sv
// ----------------------------------------------------------------------------
// pfd_map: Playfair pair mapping
// Locates both letters of a pair in the key square and applies the row,
// column or rectangle rule.
// ----------------------------------------------------------------------------
module pfd_map import pfd_pkg::*; (
  input  row_t    rows_i [SideC],
  input  logic    mode_i,
  input  pair_t   pair_i,
  output letter_t first_o,
  output letter_t second_o
);

  function automatic letter_t cell_at(row_t row, coord_t c);
    letter_t v;
    unique case (c)
      3'd0:    v = row[0*LetterW +: LetterW];
      3'd1:    v = row[1*LetterW +: LetterW];
      3'd2:    v = row[2*LetterW +: LetterW];
      3'd3:    v = row[3*LetterW +: LetterW];
      3'd4:    v = row[4*LetterW +: LetterW];
      default: v = row[0*LetterW +: LetterW];
    endcase
    return v;
  endfunction

  // first match in row-major order; absent letters sit at the origin
  function automatic pos_t locate(row_t rows [SideC], letter_t l);
    pos_t p;
    p = '0;
    for (int r = SideC - 1; r >= 0; r--) begin
      for (int c = SideC - 1; c >= 0; c--) begin
        if (rows[r][c*LetterW +: LetterW] == l) begin
          p.row = coord_t'(r);
          p.col = coord_t'(c);
        end
      end
    end
    return p;
  endfunction

  pos_t pa, pb;

  always_comb begin
    pa = locate(rows_i, pair_i.first);
    pb = locate(rows_i, pair_i.second);
    if (pa.row == pb.row) begin
      first_o  = cell_at(rows_i[pa.row], wrap_step(pa.col, mode_i));
      second_o = cell_at(rows_i[pa.row], wrap_step(pb.col, mode_i));
    end else if (pa.col == pb.col) begin
      first_o  = cell_at(rows_i[wrap_step(pa.row, mode_i)], pa.col);
      second_o = cell_at(rows_i[wrap_step(pb.row, mode_i)], pa.col);
    end else begin
      first_o  = cell_at(rows_i[pa.row], pb.col);
      second_o = cell_at(rows_i[pb.row], pa.col);
    end
  end

endmodule

// File: rtl/core/playfair_digram_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digram_cipher: streaming Playfair cipher over a 5x5 key square
// Pairs incoming letters, maps each pair and streams the result letters.
// ----------------------------------------------------------------------------
// Input channel: one symbol per transaction (letter 0..25, anything higher is
// a space and dropped); message_end flushes a pending letter with the filler.
// Output channel: one letter per transaction; run_last marks the last letter
// caused by an input transaction. An input may cause zero to four letters.
// Pipeline: pairing register, mapping register, output register.
// Throughput: the mapping path takes a new pair every cycle while the letter
// buffer is free; the output port moves one letter a cycle while the receiver
// is ready, so the result letters of an input occupy the output one by one.
// Inputs that only hold a letter cause no output letters.
// A stalled receiver holds the output register; the mapping and pairing
// registers keep accepting until they are full, then in_ready_o drops.
// Reset clears the pending letter and all pipeline valids and loads the
// default registers: encrypt, filler x, alphabetical square without j.
// Registers (APB, word-aligned byte addresses): mode, filler_letter, square_row0..4.
// ----------------------------------------------------------------------------
module playfair_digram_cipher import pfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  letter_t          symbol_i,
  input  logic             message_end_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output letter_t          out_letter_o,
  output logic             run_last_o,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // configuration registers
  logic    mode_q;
  letter_t filler_q;
  row_t    rows_q [SideC];
  reg_idx_e reg_idx;
  logic    cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeRst;
      filler_q  <= FillerRst;
      rows_q[0] <= Row0Rst;
      rows_q[1] <= Row1Rst;
      rows_q[2] <= Row2Rst;
      rows_q[3] <= Row3Rst;
      rows_q[4] <= Row4Rst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegMode:   mode_q    <= pwdata[0];
        RegFiller: filler_q  <= pwdata[LetterW-1:0];
        RegRow0:   rows_q[0] <= pwdata[RowW-1:0];
        RegRow1:   rows_q[1] <= pwdata[RowW-1:0];
        RegRow2:   rows_q[2] <= pwdata[RowW-1:0];
        RegRow3:   rows_q[3] <= pwdata[RowW-1:0];
        RegRow4:   rows_q[4] <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegMode:   prdata = {{(DataW-1){1'b0}}, mode_q};
      RegFiller: prdata = {{(DataW-LetterW){1'b0}}, filler_q};
      RegRow0:   prdata = {{(DataW-RowW){1'b0}}, rows_q[0]};
      RegRow1:   prdata = {{(DataW-RowW){1'b0}}, rows_q[1]};
      RegRow2:   prdata = {{(DataW-RowW){1'b0}}, rows_q[2]};
      RegRow3:   prdata = {{(DataW-RowW){1'b0}}, rows_q[3]};
      RegRow4:   prdata = {{(DataW-RowW){1'b0}}, rows_q[4]};
      default:   prdata = '0;
    endcase
  end

  // pairing
  letter_t fill;
  letter_t sym_l;
  logic    in_acc;
  letter_t held_q, held_d;
  logic    held_v_q, held_v_d;
  logic    job_new;
  pair_t   job_pair_d;
  logic    job_rep_d;

  assign fill   = fold_letter(filler_q);
  assign sym_l  = fold_letter(symbol_i);
  assign in_acc = in_valid_i && in_ready_o;

  // a doubled letter at message end gives the same pair twice: carried as repeat
  always_comb begin
    held_d     = held_q;
    held_v_d   = held_v_q;
    job_new    = 1'b0;
    job_pair_d = '{first: held_q, second: fill};
    job_rep_d  = 1'b0;
    if (symbol_i <= LastLetter) begin
      if (!held_v_q) begin
        held_d   = sym_l;
        held_v_d = 1'b1;
        if (message_end_i) begin
          job_new    = 1'b1;
          job_pair_d = '{first: sym_l, second: fill};
          held_d     = '0;
          held_v_d   = 1'b0;
        end
      end else if (held_q == sym_l) begin
        job_new = 1'b1;
        if (message_end_i) begin
          job_rep_d = 1'b1;
          held_d    = '0;
          held_v_d  = 1'b0;
        end
      end else begin
        job_new    = 1'b1;
        job_pair_d = '{first: held_q, second: sym_l};
        held_d     = '0;
        held_v_d   = 1'b0;
      end
    end else if (message_end_i && held_v_q) begin
      job_new  = 1'b1;
      held_d   = '0;
      held_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else if (in_acc) begin
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

  // pair register
  logic  job_v_q;
  pair_t job_pair_q;
  logic  job_rep_q;
  logic  job_move;
  logic  emit_free;

  assign job_move   = job_v_q && emit_free;
  assign in_ready_o = !job_v_q || job_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
    end else if (in_acc) begin
      job_v_q <= job_new;
    end else if (job_move) begin
      job_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && job_new) begin
      job_pair_q <= job_pair_d;
      job_rep_q  <= job_rep_d;
    end
  end

  // mapping
  letter_t map_a, map_b;
  logic    keep_a, keep_b;

  pfd_map u_map (
    .rows_i   (rows_q),
    .mode_i   (mode_q),
    .pair_i   (job_pair_q),
    .first_o  (map_a),
    .second_o (map_b)
  );

  assign keep_a = !(mode_q && (map_a == fill));
  assign keep_b = !(mode_q && (map_b == fill));

  // letter buffer: slots a, b, a, b
  logic [3:0] emit_mask_q;
  letter_t    emit_a_q, emit_b_q;
  logic [3:0] mask_rest;
  logic [3:0] mask_low;
  logic       out_take;
  logic       emit_pop;
  logic       out_valid_q;
  letter_t    out_letter_q;
  logic       run_last_q;

  assign out_take  = !out_valid_q || out_ready_i;
  assign emit_pop  = out_take && (emit_mask_q != 4'd0);
  assign mask_rest = emit_mask_q & (emit_mask_q - 4'd1);
  assign mask_low  = emit_mask_q & ~(emit_mask_q - 4'd1);
  assign emit_free = (emit_mask_q == 4'd0) || (out_take && (mask_rest == 4'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_mask_q <= 4'd0;
    end else if (job_move) begin
      emit_mask_q <= {job_rep_q && keep_b, job_rep_q && keep_a, keep_b, keep_a};
    end else if (emit_pop) begin
      emit_mask_q <= mask_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_move) begin
      emit_a_q <= map_a;
      emit_b_q <= map_b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_pop) begin
      out_letter_q <= (mask_low[1] || mask_low[3]) ? emit_b_q : emit_a_q;
      run_last_q   <= (mask_rest == 4'd0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign run_last_o   = run_last_q;

  // checks
  a_held_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_v_q |-> (held_q != LetterJ))
    else $error("pending letter not folded");

  a_end_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && message_end_i) |=> !held_v_q)
    else $error("letter still pending after message end");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !run_last_o) |-> (emit_mask_q != 4'd0))
    else $error("run ended without run_last");

endmodule
